[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and character helpers for the hex record decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EOF    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_COLON = 3'd1;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM = 3'd3;
    localparam logic [2:0] ERR_TYPE     = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;

    // record types
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_SEG     = 8'h02;
    localparam logic [7:0] REC_START_S = 8'h03;
    localparam logic [7:0] REC_LINEAR  = 8'h04;
    localparam logic [7:0] REC_START_L = 8'h05;

    // byte positions inside a record
    localparam logic [8:0] IDX_LENGTH  = 9'd0;
    localparam logic [8:0] IDX_OFF_HI  = 9'd1;
    localparam logic [8:0] IDX_OFF_LO  = 9'd2;
    localparam logic [8:0] IDX_TYPE    = 9'd3;
    localparam logic [8:0] IDX_DATA    = 9'd4;
    localparam logic [8:0] IDX_BASE_LO = 9'd5;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_READ,
        PH_EOL,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic       is_colon;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] nibble;
    } t_char_info;

    function automatic t_char_info decode_char(input logic [7:0] c);
        t_char_info info;
        logic [7:0] low;
        logic [7:0] diff;
        low = c | CASE_BIT;
        info.is_colon = (c == CHAR_COLON);
        info.is_lf    = (c == CHAR_LF);
        info.is_hex   = 1'b0;
        info.nibble   = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff        = c - CHAR_ZERO;
            info.is_hex = 1'b1;
            info.nibble = diff[3:0];
        end else if (low >= CHAR_LOW_A && low <= CHAR_LOW_F) begin
            diff        = low - CHAR_LOW_A + 8'd10;
            info.is_hex = 1'b1;
            info.nibble = diff[3:0];
        end
        return info;
    endfunction

endpackage

`default_nettype wire

[rtl/intel_hex_record_decoder.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_decoder
// Decodes an ASCII hex-record stream, one character per request.
//
// Input channel: i_in_valid / o_in_stall with i_char_code. Output channel:
// o_out_valid / i_out_stall with the result fields. A character produces
// zero or one result: tentative data bytes, a record-accepted or end-of-file
// result on the checksum byte, or one sticky error.
// A taken character passes the input register, then the result register.
// Throughput: one character per cycle while the receiver does not stall;
// the parse state update is a single pass of byte assembly, 32-bit adds
// and compares per character. When the receiver stalls, the result
// register holds its value and the input register fills; o_in_stall
// rises only once both are occupied. Characters that give no result are
// held too while a result waits: the parser takes a character only if
// the result register is free or being drained.
// Reset (i_rst_n low, synchronous) returns the parser to line start with
// the base, marks and error state cleared and both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_decoder
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_code,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_error_code,
    output logic [31:0]      o_byte_address,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_record_kind,
    output logic [31:0]      o_lowest_address,
    output logic [31:0]      o_end_address,
    output logic             o_image_seen
);

    logic       take;
    logic       stage_valid;
    t_char_info stage_info;

    ihex_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_char_code (i_char_code),
        .o_in_stall  (o_in_stall),
        .i_take      (take),
        .o_valid     (stage_valid),
        .o_info      (stage_info)
    );

    ihex_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (stage_valid),
        .i_info           (stage_info),
        .o_take           (take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_error_code     (o_error_code),
        .o_byte_address   (o_byte_address),
        .o_data_byte      (o_data_byte),
        .o_record_kind    (o_record_kind),
        .o_lowest_address (o_lowest_address),
        .o_end_address    (o_end_address),
        .o_image_seen     (o_image_seen)
    );

endmodule

`default_nettype wire

[rtl/ihex_in_stage.sv]
// ----------------------------------------------------------------------------
// ihex_in_stage
// Input register: takes one character and holds its decoded class.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_in_stage
    import ihex_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_char_code,
    output logic            o_in_stall,
    input  wire logic       i_take,
    output logic            o_valid,
    output t_char_info      o_info
);

    logic       r_valid;
    t_char_info r_info;
    logic       accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_info <= decode_char(i_char_code);
        end
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;

endmodule

`default_nettype wire

[rtl/ihex_parser.sv]
// ----------------------------------------------------------------------------
// ihex_parser
// Record state machine, address tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_parser
    import ihex_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_char_info  i_info,
    output logic             o_take,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_error_code,
    output logic [31:0]      o_byte_address,
    output logic [7:0]       o_data_byte,
    output logic [7:0]       o_record_kind,
    output logic [31:0]      o_lowest_address,
    output logic [31:0]      o_end_address,
    output logic             o_image_seen
);

    // parse state
    t_phase      r_phase,     n_phase;
    logic        r_low_next,  n_low_next;
    logic [3:0]  r_high,      n_high;
    logic [8:0]  r_count,     n_count;
    logic [7:0]  r_len,       n_len;
    logic [15:0] r_offset,    n_offset;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_sum,       n_sum;
    logic [15:0] r_base_word, n_base_word;
    logic [31:0] r_ext,       n_ext;
    logic [31:0] r_start,     n_start;
    logic [31:0] r_addr,      n_addr;
    logic [31:0] r_low,       n_low;
    logic [31:0] r_end,       n_end;
    logic        r_seen,      n_seen;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [2:0]  r_err;
    logic [31:0] r_baddr;
    logic [7:0]  r_data;
    logic [7:0]  r_rkind;
    logic [31:0] r_lowest;
    logic [31:0] r_endaddr;
    logic        r_imseen;

    logic        emit;
    logic [1:0]  e_kind;
    logic [2:0]  e_err;
    logic [31:0] e_addr;
    logic [7:0]  e_data;

    logic [7:0]  byte_val;
    logic [8:0]  data_limit;
    logic [31:0] rec_end;

    assign o_take     = i_valid && (!r_out_valid || !i_out_stall);
    assign byte_val   = {r_high, i_info.nibble};
    assign data_limit = IDX_DATA + {1'b0, r_len};
    assign rec_end    = r_start + {24'd0, r_len};

    always_comb begin
        n_phase     = r_phase;
        n_low_next  = r_low_next;
        n_high      = r_high;
        n_count     = r_count;
        n_len       = r_len;
        n_offset    = r_offset;
        n_type      = r_type;
        n_sum       = r_sum;
        n_base_word = r_base_word;
        n_ext       = r_ext;
        n_start     = r_start;
        n_addr      = r_addr;
        n_low       = r_low;
        n_end       = r_end;
        n_seen      = r_seen;
        emit        = 1'b0;
        e_kind      = KIND_ERROR;
        e_err       = ERR_NONE;
        e_addr      = 32'd0;
        e_data      = 8'd0;

        case (r_phase)
            PH_LINE: begin
                if (!i_info.is_colon) begin
                    n_phase = PH_ERROR;
                    emit    = 1'b1;
                    e_err   = ERR_NO_COLON;
                end else begin
                    n_phase     = PH_READ;
                    n_low_next  = 1'b0;
                    n_high      = 4'd0;
                    n_count     = 9'd0;
                    n_len       = 8'd0;
                    n_offset    = 16'd0;
                    n_type      = 8'd0;
                    n_sum       = 8'd0;
                    n_base_word = 16'd0;
                end
            end
            PH_EOL: begin
                if (i_info.is_lf) begin
                    n_phase = PH_LINE;
                end
            end
            PH_READ: begin
                if (i_info.is_lf) begin
                    n_phase = PH_ERROR;
                    emit    = 1'b1;
                    e_err   = ERR_TRUNC;
                end else if (!i_info.is_hex) begin
                    n_phase = PH_ERROR;
                    emit    = 1'b1;
                    e_err   = ERR_BAD_HEX;
                end else if (!r_low_next) begin
                    n_high     = i_info.nibble;
                    n_low_next = 1'b1;
                end else begin
                    n_low_next = 1'b0;
                    n_sum      = r_sum + byte_val;
                    n_count    = r_count + 9'd1;
                    if (r_count == IDX_LENGTH) begin
                        n_len = byte_val;
                    end else if (r_count == IDX_OFF_HI) begin
                        n_offset = {byte_val, 8'd0};
                    end else if (r_count == IDX_OFF_LO) begin
                        n_offset = {r_offset[15:8], byte_val};
                    end else if (r_count == IDX_TYPE) begin
                        // base and offset are settled here: latch the record start
                        n_type  = byte_val;
                        n_start = r_ext + {16'd0, r_offset};
                        n_addr  = r_ext + {16'd0, r_offset};
                    end else if (r_count < data_limit) begin
                        if (r_type == REC_DATA) begin
                            emit   = 1'b1;
                            e_kind = KIND_DATA;
                            e_addr = r_addr;
                            e_data = byte_val;
                            n_addr = r_addr + 32'd1;
                        end else if (r_count == IDX_DATA || r_count == IDX_BASE_LO) begin
                            n_base_word = {r_base_word[7:0], byte_val};
                        end
                    end else begin
                        // checksum byte closes the record
                        n_phase = PH_EOL;
                        emit    = 1'b1;
                        if (n_sum != 8'd0) begin
                            n_phase = PH_ERROR;
                            e_err   = ERR_CHECKSUM;
                        end else begin
                            case (r_type)
                                REC_DATA: begin
                                    e_kind = KIND_RECORD;
                                    e_addr = r_start;
                                    n_seen = 1'b1;
                                    if (!r_seen) begin
                                        n_low = r_start;
                                        n_end = rec_end;
                                    end else begin
                                        if (r_start < r_low) begin
                                            n_low = r_start;
                                        end
                                        if (rec_end > r_end) begin
                                            n_end = rec_end;
                                        end
                                    end
                                end
                                REC_EOF: begin
                                    n_phase = PH_DONE;
                                    e_kind  = KIND_EOF;
                                    e_addr  = r_start;
                                end
                                REC_SEG: begin
                                    n_ext  = {12'd0, r_base_word, 4'd0};
                                    e_kind = KIND_RECORD;
                                    e_addr = r_start;
                                end
                                REC_LINEAR: begin
                                    n_ext  = {r_base_word, 16'd0};
                                    e_kind = KIND_RECORD;
                                    e_addr = r_start;
                                end
                                REC_START_S, REC_START_L: begin
                                    e_kind = KIND_RECORD;
                                    e_addr = r_start;
                                end
                                default: begin
                                    n_phase = PH_ERROR;
                                    e_err   = ERR_TYPE;
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE;
            r_low_next  <= 1'b0;
            r_high      <= 4'd0;
            r_count     <= 9'd0;
            r_len       <= 8'd0;
            r_offset    <= 16'd0;
            r_type      <= 8'd0;
            r_sum       <= 8'd0;
            r_base_word <= 16'd0;
            r_ext       <= 32'd0;
            r_start     <= 32'd0;
            r_addr      <= 32'd0;
            r_low       <= 32'd0;
            r_end       <= 32'd0;
            r_seen      <= 1'b0;
        end else if (o_take) begin
            r_phase     <= n_phase;
            r_low_next  <= n_low_next;
            r_high      <= n_high;
            r_count     <= n_count;
            r_len       <= n_len;
            r_offset    <= n_offset;
            r_type      <= n_type;
            r_sum       <= n_sum;
            r_base_word <= n_base_word;
            r_ext       <= n_ext;
            r_start     <= n_start;
            r_addr      <= n_addr;
            r_low       <= n_low;
            r_end       <= n_end;
            r_seen      <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_kind    <= e_kind;
            r_err     <= e_err;
            r_baddr   <= e_addr;
            r_data    <= e_data;
            r_rkind   <= n_type;
            r_lowest  <= n_low;
            r_endaddr <= n_end;
            r_imseen  <= n_seen;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_error_code     = r_err;
    assign o_byte_address   = r_baddr;
    assign o_data_byte      = r_data;
    assign o_record_kind    = r_rkind;
    assign o_lowest_address = r_lowest;
    assign o_end_address    = r_endaddr;
    assign o_image_seen     = r_imseen;

endmodule

`default_nettype wire
